@@ design/lsgs_pkg.sv @@
// shared types, constants and arithmetic helpers of the gaussian solver
package lsgs_pkg;

  localparam int unsigned MaxOrderDefault = 8;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned OrderW          = 5;
  localparam int unsigned RowW            = 4;
  localparam int unsigned ColW            = 5;
  localparam int unsigned DataW           = 32;
  localparam logic [OrderW-1:0] OrderReset = 5'd8;

  // input transfer payload
  typedef struct packed {
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         column;
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [RowW-1:0]         index;
    logic signed [DataW-1:0] solution_value;
    logic                    final_res;
    logic                    zero_pivot;
  } out_item_t;

  // datapath operations
  typedef enum logic [2:0] {
    OpNone,
    OpLoadPiv,
    OpDivStart,
    OpMulSub,
    OpAccClr,
    OpMulAcc,
    OpBackDiv,
    OpClrErr
  } dp_op_e;

  // controller to datapath command
  typedef struct packed {
    dp_op_e          op;
    logic [RowW-1:0] row_k;
    logic [RowW-1:0] row_i;
    logic [ColW-1:0] col_j;
  } dp_cmd_t;

  // datapath status
  typedef struct packed {
    logic done;
  } dp_sts_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction

endpackage

@@ design/lsgs_div.sv @@
// radix-2 restoring divider for fixed-point quotients, one bit a cycle
module lsgs_div #(
  parameter int unsigned FracBits = lsgs_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lsgs_pkg::DataW-1:0] num_i,
  input  logic signed [lsgs_pkg::DataW-1:0] den_i,
  output logic                              busy_o,
  output logic signed [lsgs_pkg::DataW-1:0] quot_o
);
  import lsgs_pkg::*;

  localparam int unsigned NumW = DataW + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]        num_q, num_d;
  logic [DataW-1:0]       den_q, den_d;
  logic [NumW:0]          rem_q, rem_d;
  logic [NumW-1:0]        quo_q, quo_d;
  logic                   neg_q, neg_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic [NumW:0]          trial;
  logic signed [NumW+1:0] sq;

  // magnitude setup and one quotient bit per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[NumW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d  = num_i[DataW-1]
               ? NumW'((NumW'(-{{FracBits{num_i[DataW-1]}}, num_i})) << FracBits)
               : NumW'((NumW'({{FracBits{1'b0}}, num_i})) << FracBits);
      den_d  = den_i[DataW-1] ? DataW'(-den_i) : den_i;
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {{(NumW+1-DataW){1'b0}}, den_q}) begin
        rem_d = trial - {{(NumW+1-DataW){1'b0}}, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      num_d = {num_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  // signed and saturated quotient
  assign sq     = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign quot_o = sat32(66'(sq));
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end
endmodule

@@ design/lsgs_datapath.sv @@
// matrix memory, multiplier, divider and accumulator of the solver
module lsgs_datapath #(
  parameter int unsigned MaxOrder = lsgs_pkg::MaxOrderDefault,
  parameter int unsigned FracBits = lsgs_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [lsgs_pkg::RowW-1:0]         wr_row_i,
  input  logic [lsgs_pkg::ColW-1:0]         wr_col_i,
  input  logic signed [lsgs_pkg::DataW-1:0] wr_val_i,
  input  logic [lsgs_pkg::ColW-1:0]         n_i,
  input  lsgs_pkg::dp_cmd_t                 cmd_i,
  output lsgs_pkg::dp_sts_t                 sts_o,
  output logic                              zp_o,
  output logic signed [lsgs_pkg::DataW-1:0] sol_o
);
  import lsgs_pkg::*;

  localparam int unsigned Cols  = MaxOrder + 1;
  localparam int unsigned Depth = MaxOrder * Cols;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SW    = $clog2(MaxOrder);

  logic signed [DataW-1:0] mem [Depth];
  logic signed [DataW-1:0] sol [MaxOrder];

  logic signed [DataW-1:0] piv_q, mult_q, acc_q, rd_q, sol_rd_q;
  logic signed [DataW-1:0] rhs_q;
  logic                    zp_q;
  logic [2:0]              ph_q;
  logic                    div_start, div_busy;
  logic signed [DataW-1:0] div_num, div_den, div_quot;
  logic signed [63:0]      prod_q;
  logic signed [DataW-1:0] prod_sat;
  logic [AW-1:0]           a_ij, a_kj, a_ik, a_ikk;
  logic [SW-1:0]           s_j;
  logic                    div_zero;

  function automatic logic [AW-1:0] addr(input logic [RowW-1:0] r,
                                         input logic [ColW-1:0] c);
    return AW'(32'(r) * Cols + 32'(c));
  endfunction

  assign a_ij  = addr(cmd_i.row_i, cmd_i.col_j);
  assign a_kj  = addr(cmd_i.row_k, cmd_i.col_j);
  assign a_ik  = addr(cmd_i.row_i, ColW'(cmd_i.row_k));
  assign a_ikk = addr(cmd_i.row_k, ColW'(cmd_i.row_k));
  assign s_j   = SW'(cmd_i.col_j);

  // floor product shift and saturation
  always_comb begin
    logic signed [63:0] sh;
    sh = prod_q >>> FracBits;
    prod_sat = sat32(66'(sh));
  end

  // divider operands: multiplier step or back substitution
  assign div_zero  = (piv_q == '0);
  assign div_den   = piv_q;
  assign div_num   = (cmd_i.op == OpBackDiv) ? sat32(66'(rhs_q) - 66'(acc_q)) : rd_q;
  assign div_start = (cmd_i.op == OpDivStart || cmd_i.op == OpBackDiv) && ph_q == 3'd2
                     && !div_zero;

  lsgs_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  // phase sequencing per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
      zp_q <= 1'b0;
      sts_o <= '0;
    end else if (sts_o.done) begin
      // command finished, rewind for the next one
      ph_q <= '0;
      sts_o.done <= 1'b0;
    end else begin
      sts_o.done <= 1'b0;
      case (cmd_i.op)
        OpNone: ph_q <= '0;
        OpClrErr: begin
          ph_q <= '0;
          zp_q <= 1'b0;
        end
        OpAccClr: begin
          if (ph_q == 3'd0) begin
            ph_q <= 3'd1;
            sts_o.done <= 1'b1;
          end
        end
        OpLoadPiv: begin
          if (ph_q == 3'd0) ph_q <= 3'd1;
          else if (ph_q == 3'd1) ph_q <= 3'd2;
          else if (ph_q == 3'd2) begin
            ph_q <= 3'd3;
            sts_o.done <= 1'b1;
          end
        end
        OpDivStart, OpBackDiv: begin
          if (ph_q == 3'd0) ph_q <= 3'd1;
          else if (ph_q == 3'd1) ph_q <= 3'd2;
          else if (ph_q == 3'd2) begin
            if (div_zero) begin
              zp_q <= 1'b1;
              ph_q <= 3'd5;
            end else ph_q <= 3'd3;
          end else if (ph_q == 3'd3) ph_q <= 3'd4;
          else if (ph_q == 3'd4) begin
            if (!div_busy) ph_q <= 3'd5;
          end else if (ph_q == 3'd5) begin
            ph_q <= 3'd6;
            sts_o.done <= 1'b1;
          end
        end
        OpMulSub, OpMulAcc: begin
          if (ph_q == 3'd4) begin
            ph_q <= 3'd5;
            sts_o.done <= 1'b1;
          end else if (ph_q < 3'd4) ph_q <= ph_q + 3'd1;
        end
        default: ph_q <= '0;
      endcase
    end
  end

  // memory, multiplier and accumulator
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[addr(wr_row_i, wr_col_i)] <= wr_val_i;
    sol_rd_q <= sol[s_j];
    case (cmd_i.op)
      OpLoadPiv: begin
        if (ph_q == 3'd0) rd_q <= mem[a_ikk];
        if (ph_q == 3'd1) piv_q <= rd_q;
      end
      OpDivStart: begin
        if (ph_q == 3'd0) rd_q <= mem[a_ik];
        if (ph_q == 3'd5) mult_q <= div_zero ? '0 : div_quot;
      end
      OpMulSub: begin
        if (ph_q == 3'd0) rd_q <= mem[a_kj];
        if (ph_q == 3'd1) prod_q <= 64'(mult_q) * 64'(rd_q);
        if (ph_q == 3'd2) rd_q <= mem[a_ij];
        if (ph_q == 3'd3) acc_q <= prod_sat;
        if (ph_q == 3'd4) mem[a_ij] <= sat32(66'(rd_q) - 66'(acc_q));
      end
      OpAccClr: begin
        acc_q <= '0;
        rhs_q <= mem[addr(cmd_i.row_k, n_i)];
      end
      OpMulAcc: begin
        if (ph_q == 3'd0) rd_q <= mem[addr(cmd_i.row_k, cmd_i.col_j)];
        if (ph_q == 3'd2) prod_q <= 64'(rd_q) * 64'(sol_rd_q);
        if (ph_q == 3'd3) mult_q <= prod_sat;
        if (ph_q == 3'd4) acc_q <= sat32(66'(acc_q) + 66'(mult_q));
      end
      OpBackDiv: begin
        if (ph_q == 3'd0) rd_q <= mem[a_ikk];
        if (ph_q == 3'd1) piv_q <= rd_q;
        if (ph_q == 3'd5) sol[SW'(cmd_i.row_k)] <= div_zero ? '0 : div_quot;
      end
      default: ;
    endcase
  end

  assign zp_o  = zp_q;
  assign sol_o = sol_rd_q;
endmodule

@@ design/lsgs_ctrl.sv @@
// sequencer for elimination, back substitution and result output
module lsgs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [lsgs_pkg::ColW-1:0] n_i,
  input  lsgs_pkg::dp_sts_t         sts_i,
  input  logic                      zp_i,
  input  logic signed [lsgs_pkg::DataW-1:0] sol_i,
  output lsgs_pkg::dp_cmd_t         cmd_o,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output lsgs_pkg::out_item_t       res_o
);
  import lsgs_pkg::*;

  typedef enum logic [3:0] {
    Idle, Clear, Piv, Mdiv, Msub, Acc, Mac, Bdiv, Outr, Outw, Outp
  } st_e;

  st_e st_q;
  logic [RowW-1:0] k_q, i_q;
  logic [ColW-1:0] j_q;
  logic            res_v_q;
  out_item_t       res_q;

  // command driven by state
  always_comb begin
    cmd_o       = '0;
    cmd_o.row_k = k_q;
    cmd_o.row_i = i_q;
    cmd_o.col_j = j_q;
    case (st_q)
      Clear: cmd_o.op = OpClrErr;
      Piv:   cmd_o.op = OpLoadPiv;
      Mdiv:  cmd_o.op = OpDivStart;
      Msub:  cmd_o.op = OpMulSub;
      Acc:   cmd_o.op = OpAccClr;
      Mac:   cmd_o.op = OpMulAcc;
      Bdiv:  cmd_o.op = OpBackDiv;
      default: cmd_o.op = OpNone;
    endcase
  end

  // main sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= Idle; k_q <= '0; i_q <= '0; j_q <= '0; res_v_q <= 1'b0;
    end else begin
      res_v_q <= 1'b0;
      case (st_q)
        Idle: if (go_i) st_q <= Clear;
        Clear: begin
          k_q <= '0;
          st_q <= (n_i == ColW'(1)) ? Acc : Piv;
        end
        Piv: if (sts_i.done) begin
          i_q <= k_q + 1'b1;
          st_q <= Mdiv;
        end
        Mdiv: if (sts_i.done) begin
          j_q <= ColW'(k_q) + 1'b1;
          st_q <= Msub;
        end
        Msub: if (sts_i.done) begin
          if (j_q != n_i) j_q <= j_q + 1'b1;
          else if (ColW'(i_q) + 1'b1 != n_i) begin
            i_q <= i_q + 1'b1;
            st_q <= Mdiv;
          end else if (ColW'(k_q) + 2'd2 != n_i) begin
            k_q <= k_q + 1'b1;
            st_q <= Piv;
          end else begin
            k_q <= RowW'(n_i - 1'b1);
            st_q <= Acc;
          end
        end
        Acc: if (sts_i.done) begin
          if (n_i == ColW'(1)) k_q <= '0;
          j_q <= ColW'(k_q) + 1'b1;
          st_q <= (ColW'(k_q) + 1'b1 == n_i || n_i == ColW'(1)) ? Bdiv : Mac;
        end
        Mac: if (sts_i.done) begin
          if (j_q + 1'b1 == n_i) st_q <= Bdiv;
          else j_q <= j_q + 1'b1;
        end
        Bdiv: if (sts_i.done) begin
          if (k_q == '0) begin
            j_q <= '0;
            st_q <= Outr;
          end else begin
            k_q <= k_q - 1'b1;
            st_q <= Acc;
          end
        end
        Outr: st_q <= Outw;
        Outw: st_q <= Outp;
        Outp: begin
          res_v_q <= 1'b1;
          res_q.index <= RowW'(j_q);
          res_q.solution_value <= sol_i;
          res_q.final_res <= (j_q + 1'b1 == n_i);
          res_q.zero_pivot <= zp_i;
          if (j_q + 1'b1 == n_i) st_q <= Idle;
          else begin
            j_q <= j_q + 1'b1;
            st_q <= Outr;
          end
        end
        default: st_q <= Idle;
      endcase
    end
  end

  assign busy_o      = (st_q != Idle);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
endmodule

@@ design/linear_system_gaussian_solver_core.sv @@
// top level of the gaussian elimination solver
// Loads one matrix entry per cycle while busy is low; an entry with last set
// is stored if its row and column are in range and starts the solve, during
// which busy stays high. Solve time is set by the one-bit-a-cycle divider,
// used once per multiplier and once per unknown, plus the multiply-subtract
// and multiply-accumulate steps. Results then come out one per pass through
// the Outr, Outw and Outp states on res_valid_o, each for one cycle only, as
// the receiver cannot stall; index order, final_res on last.
module linear_system_gaussian_solver_core #(
  parameter int unsigned MaxOrder = lsgs_pkg::MaxOrderDefault,
  parameter int unsigned FracBits = lsgs_pkg::FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lsgs_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output lsgs_pkg::out_item_t  res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [0:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lsgs_pkg::*;

  logic [OrderW-1:0] order_q;
  logic [ColW-1:0]   n;
  logic              acc, wr_ok, go;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              zp;
  logic signed [DataW-1:0] sol;

  // configuration register transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= OrderReset;
    else if (psel && penable && pwrite && paddr == 1'b0) order_q <= pwdata[OrderW-1:0];
  end
  assign pready = 1'b1;
  assign prdata = {{(32-OrderW){1'b0}}, order_q};

  // effective order
  always_comb begin
    if (order_q == '0) n = ColW'(1);
    else if (32'(order_q) > MaxOrder) n = ColW'(MaxOrder);
    else n = order_q;
  end

  assign acc   = start && !busy;
  assign wr_ok = acc && (ColW'(item_i.row) < n) && (item_i.column <= n);
  assign go    = acc && item_i.last;

  lsgs_datapath #(.MaxOrder(MaxOrder), .FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .wr_en_i(wr_ok), .wr_row_i(item_i.row), .wr_col_i(item_i.column),
    .wr_val_i(item_i.value), .n_i(n), .cmd_i(cmd), .sts_o(sts), .zp_o(zp), .sol_o(sol)
  );

  lsgs_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .n_i(n), .sts_i(sts), .zp_i(zp), .sol_i(sol),
    .cmd_o(cmd), .busy_o(busy), .res_valid_o, .res_o
  );
endmodule
